// ----- src/scar_pkg.sv -----
// ----------------------------------------------------------------------------
// scar_pkg: shared types, constants and helpers of the stereo reverb
// Sample and coefficient formats, register indexes, comb base lengths and
// the command/status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package scar_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 11;
  localparam int unsigned MS_W     = 7;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned V_W      = 28;
  localparam int unsigned MUL_B_W  = 12;

  localparam int unsigned SAMPLE_RATE  = 44100;
  localparam int unsigned MAX_PREDELAY = 8192;
  localparam int unsigned COMB_DEPTH   = 2048;

  // ms * rate stays below 2^24 over the whole rate range
  localparam int unsigned PD_PROD_W = 24;
  // floor(x / 1000) = (x * RECIP_M) >> RECIP_SH, exact for x < 2^24
  localparam logic [24:0] RECIP_M  = 25'd17179870;
  localparam int unsigned RECIP_SH = 34;
  localparam int unsigned PD_QUO_W = 15;

  localparam int unsigned AP_AW = 10;
  localparam logic [AP_AW-1:0] AP_LEN0 = 10'd225;
  localparam logic [AP_AW-1:0] AP_LEN1 = 10'd556;
  localparam logic [AP_AW-1:0] AP_OFF1 = 10'd225;

  localparam logic [COEF_W-1:0] Q_ONE      = 11'd1024;
  localparam logic [9:0]        FB_BASE    = 10'd717;
  localparam logic [19:0]       WET_SCALE  = 20'd307;

  localparam logic [COEF_W-1:0] ROOM_RST  = 11'd717;
  localparam logic [COEF_W-1:0] DAMP_RST  = 11'd512;
  localparam logic [COEF_W-1:0] WET_RST   = 11'd307;
  localparam logic [MS_W-1:0]   MS_RST    = 7'd40;

  typedef enum logic [IDX_W-1:0] {
    REG_ROOM_SIZE   = 3'd0,
    REG_DAMPING     = 3'd1,
    REG_WET_LEVEL   = 3'd2,
    REG_PREDELAY_MS = 3'd3,
    REG_ENABLED     = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD,
    OP_PD_MUL, OP_PD_DIV, OP_PD_WR, OP_PD_RD, OP_PD_TAKE,
    OP_CB_LEN, OP_CB_RD, OP_CB_LP1, OP_CB_LP2, OP_CB_FS, OP_CB_FB, OP_CB_WR,
    OP_AP_RD, OP_AP_WR,
    OP_MIX1, OP_MIX2, OP_MIX3,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       ch;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    logic clr_last;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [COEF_W-1:0] comb_base(input logic ch, input logic [1:0] c);
    logic [COEF_W-1:0] b;
    case ({ch, c})
      3'd0:    b = 11'd1116;
      3'd1:    b = 11'd1188;
      3'd2:    b = 11'd1277;
      3'd3:    b = 11'd1356;
      3'd4:    b = 11'd1139;
      3'd5:    b = 11'd1211;
      3'd6:    b = 11'd1300;
      default: b = 11'd1387;
    endcase
    return b;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > $signed(ACC_W'(8388607))) begin
      r = 24'sh7FFFFF;
    end else if (v < -$signed(ACC_W'(8388608))) begin
      r = 24'sh800000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/scar_ctrl.sv -----
// ----------------------------------------------------------------------------
// scar_ctrl: reverb sequencer
// One-hot state machine that clears the memories after reset, then steps the
// datapath through predelay once per frame and comb, allpass and mix per channel.
// ----------------------------------------------------------------------------
module scar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scar_pkg::dp_sts_t sts_i,
  output scar_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_PD_MUL  = 20'h00004,
    S_PD_DIV  = 20'h00008,
    S_PD_WR   = 20'h00010,
    S_PD_RD   = 20'h00020,
    S_PD_TAKE = 20'h00040,
    S_CB_LEN  = 20'h00080,
    S_CB_RD   = 20'h00100,
    S_CB_LP1  = 20'h00200,
    S_CB_LP2  = 20'h00400,
    S_CB_FS   = 20'h00800,
    S_CB_FB   = 20'h01000,
    S_CB_WR   = 20'h02000,
    S_AP_RD   = 20'h04000,
    S_AP_WR   = 20'h08000,
    S_MIX1    = 20'h10000,
    S_MIX2    = 20'h20000,
    S_MIX3    = 20'h40000,
    S_DONE    = 20'h80000
  } state_e;

  state_e     state_q, state_d;
  logic       ch_q, ch_d;
  logic [1:0] cnt_q, cnt_d;
  scar_pkg::dp_op_e op;

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    cnt_d      = cnt_q;
    op         = scar_pkg::OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        op = scar_pkg::OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op      = scar_pkg::OP_LOAD;
          state_d = sts_i.enabled ? S_PD_MUL : S_DONE;
        end
      end
      S_PD_MUL: begin
        op = scar_pkg::OP_PD_MUL; state_d = S_PD_DIV;
      end
      S_PD_DIV: begin
        op = scar_pkg::OP_PD_DIV; state_d = S_PD_WR;
      end
      S_PD_WR: begin
        op = scar_pkg::OP_PD_WR; state_d = S_PD_RD;
      end
      S_PD_RD: begin
        op = scar_pkg::OP_PD_RD; state_d = S_PD_TAKE;
      end
      S_PD_TAKE: begin
        op = scar_pkg::OP_PD_TAKE; state_d = S_CB_LEN;
      end
      S_CB_LEN: begin
        op = scar_pkg::OP_CB_LEN; state_d = S_CB_RD;
      end
      S_CB_RD: begin
        op = scar_pkg::OP_CB_RD; state_d = S_CB_LP1;
      end
      S_CB_LP1: begin
        op = scar_pkg::OP_CB_LP1; state_d = S_CB_LP2;
      end
      S_CB_LP2: begin
        op = scar_pkg::OP_CB_LP2; state_d = S_CB_FS;
      end
      S_CB_FS: begin
        op = scar_pkg::OP_CB_FS; state_d = S_CB_FB;
      end
      S_CB_FB: begin
        op = scar_pkg::OP_CB_FB; state_d = S_CB_WR;
      end
      S_CB_WR: begin
        op = scar_pkg::OP_CB_WR;
        if (cnt_q == 2'd3) begin
          cnt_d   = 2'd0;
          state_d = S_AP_RD;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = S_CB_LEN;
        end
      end
      S_AP_RD: begin
        op = scar_pkg::OP_AP_RD; state_d = S_AP_WR;
      end
      S_AP_WR: begin
        op = scar_pkg::OP_AP_WR;
        if (cnt_q[0]) begin
          cnt_d   = 2'd0;
          state_d = S_MIX1;
        end else begin
          cnt_d   = 2'd1;
          state_d = S_AP_RD;
        end
      end
      S_MIX1: begin
        op = scar_pkg::OP_MIX1; state_d = S_MIX2;
      end
      S_MIX2: begin
        op = scar_pkg::OP_MIX2; state_d = S_MIX3;
      end
      S_MIX3: begin
        op = scar_pkg::OP_MIX3;
        if (ch_q) begin
          ch_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          ch_d    = 1'b1;
          state_d = S_CB_LEN;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          op      = scar_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign cmd_o = '{op: op, ch: ch_q, idx: cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ch_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- src/scar_dp.sv -----
// ----------------------------------------------------------------------------
// scar_dp: reverb datapath
// Config registers, delay memories, one shared multiply-accumulate, filter
// state and the output register, driven one command per cycle.
// ----------------------------------------------------------------------------
module scar_dp #(
  parameter int unsigned SampleRate  = scar_pkg::SAMPLE_RATE,
  parameter int unsigned MaxPredelay = scar_pkg::MAX_PREDELAY,
  parameter int unsigned CombDepth   = scar_pkg::COMB_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [scar_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [scar_pkg::COEF_W-1:0]           cfg_data_i,
  input  logic signed [scar_pkg::SAMPLE_W-1:0]  left_in_i,
  input  logic signed [scar_pkg::SAMPLE_W-1:0]  right_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [scar_pkg::SAMPLE_W-1:0]  left_out_o,
  output logic signed [scar_pkg::SAMPLE_W-1:0]  right_out_o,
  input  scar_pkg::dp_cmd_t                     cmd_i,
  output scar_pkg::dp_sts_t                     sts_o
);

  localparam int unsigned SW    = scar_pkg::SAMPLE_W;
  localparam int unsigned CW    = scar_pkg::COEF_W;
  localparam int unsigned AW    = scar_pkg::ACC_W;
  localparam int unsigned VW    = scar_pkg::V_W;
  localparam int unsigned BW    = scar_pkg::MUL_B_W;
  localparam int unsigned PW    = scar_pkg::PD_PROD_W;
  localparam int unsigned QW    = scar_pkg::PD_QUO_W;
  localparam int unsigned APW   = scar_pkg::AP_AW;
  localparam int unsigned PD_AW = $clog2(MaxPredelay);
  localparam int unsigned PL_W  = $clog2(MaxPredelay + 1);
  localparam int unsigned CB_N  = 4 * CombDepth;
  localparam int unsigned CB_AW = $clog2(CB_N);
  localparam int unsigned CP_W  = $clog2(CombDepth);
  localparam int unsigned CL_W  = $clog2(CombDepth + 1);
  localparam int unsigned AP_N  = 1 << APW;
  localparam int unsigned CLR_A = (MaxPredelay > CB_N) ? MaxPredelay : CB_N;
  localparam int unsigned CLR_N = (CLR_A > AP_N) ? CLR_A : AP_N;
  localparam int unsigned CLR_W = $clog2(CLR_N + 1);

  // configuration
  logic [CW-1:0] room_q, damp_q, wet_q;
  logic [scar_pkg::MS_W-1:0] ms_q;
  logic en_q, rewind;
  logic [CW-1:0] room_c, damp_c, wet_c, one_m_d, one_m_w;
  logic [9:0] fb;
  logic [8:0] wg_calc, wg_q;

  // memories
  logic signed [SW-1:0] pd_l_mem [MaxPredelay];
  logic signed [SW-1:0] pd_r_mem [MaxPredelay];
  logic signed [SW-1:0] cb_l_mem [CB_N];
  logic signed [SW-1:0] cb_r_mem [CB_N];
  logic signed [SW-1:0] ap_l_mem [AP_N];
  logic signed [SW-1:0] ap_r_mem [AP_N];
  logic signed [SW-1:0] pd_l_rd_q, pd_r_rd_q, cb_l_rd_q, cb_r_rd_q, ap_l_rd_q, ap_r_rd_q;

  logic [PD_AW-1:0] pd_addr;
  logic pd_we, pd_re;
  logic signed [SW-1:0] pd_wd_l, pd_wd_r;
  logic [CB_AW-1:0] cb_addr;
  logic cb_we_l, cb_we_r, cb_re;
  logic signed [SW-1:0] cb_wd;
  logic [APW-1:0] ap_addr;
  logic ap_we_l, ap_we_r, ap_re;
  logic signed [SW-1:0] ap_wd;

  // state
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic signed [SW-1:0] dry_l_q, dry_l_d, dry_r_q, dry_r_d;
  logic signed [SW-1:0] res_l_q, res_l_d, res_r_q, res_r_d;
  logic signed [SW-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic out_valid_q, out_valid_d;
  logic signed [SW-1:0] wet_l_q, wet_l_d, wet_r_q, wet_r_d;
  logic [PW-1:0] pd_prod_q, pd_prod_d;
  logic [PL_W-1:0] plen_q, plen_d;
  logic [PD_AW-1:0] pd_pos_q, pd_pos_d, pd_rd_q, pd_rd_d;
  logic [CL_W-1:0] clen_q, clen_d;
  logic [CP_W-1:0] cpos_q, cpos_d;
  logic [CP_W-1:0] cb_pos_q [8];
  logic [CP_W-1:0] cb_pos_d [8];
  logic signed [SW-1:0] lp_q [8];
  logic signed [SW-1:0] lp_d [8];
  logic [APW-1:0] ap_pos_q [4];
  logic [APW-1:0] ap_pos_d [4];
  logic [APW-1:0] ap_cur_q, ap_cur_d;
  logic signed [VW-1:0] sum_q, sum_d, v_q, v_d;
  logic signed [SW-1:0] fs_q, fs_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [8:0] wg_d;

  // arithmetic
  logic signed [VW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [39:0] mul_p;
  logic mul_en, mul_clr;
  logic signed [AW-1:0] acc_rnd;
  logic signed [SW-1:0] acc_sat;
  logic [48:0] pd_div_p;
  logic [QW-1:0] pd_quo;
  logic [PL_W-1:0] plen_calc, pd_inc;
  logic [PD_AW-1:0] pd_cur, pd_nxt;
  logic [21:0] cb_len_p;
  logic [12:0] cb_len_raw;
  logic [CL_W-1:0] clen_calc, cb_inc;
  logic [CP_W-1:0] cb_cur, cb_nxt;
  logic [CB_AW-1:0] cb_off;
  logic [APW-1:0] ap_len, ap_base, ap_cur, ap_inc, ap_nxt;
  logic [2:0] k_cb;
  logic [1:0] k_ap;
  logic signed [SW-1:0] cb_rd, ap_rd, x_wet, dry_sel;
  logic signed [VW-1:0] bo_half;

  assign room_c  = (room_q > scar_pkg::Q_ONE) ? scar_pkg::Q_ONE : room_q;
  assign damp_c  = (damp_q > scar_pkg::Q_ONE) ? scar_pkg::Q_ONE : damp_q;
  assign wet_c   = (wet_q > scar_pkg::Q_ONE) ? scar_pkg::Q_ONE : wet_q;
  assign one_m_d = scar_pkg::Q_ONE - damp_c;
  assign one_m_w = scar_pkg::Q_ONE - wet_c;
  assign fb      = scar_pkg::FB_BASE + 10'(({1'b0, room_c} + 12'd2) >> 2);
  assign wg_calc = 9'((20'(wet_c) * scar_pkg::WET_SCALE + 20'd512) >> 10);

  assign rewind = cfg_we_i && (cfg_idx_i == scar_pkg::REG_ROOM_SIZE ||
                               cfg_idx_i == scar_pkg::REG_DAMPING ||
                               cfg_idx_i == scar_pkg::REG_PREDELAY_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= scar_pkg::ROOM_RST;
      damp_q <= scar_pkg::DAMP_RST;
      wet_q  <= scar_pkg::WET_RST;
      ms_q   <= scar_pkg::MS_RST;
      en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scar_pkg::REG_ROOM_SIZE:   room_q <= cfg_data_i;
        scar_pkg::REG_DAMPING:     damp_q <= cfg_data_i;
        scar_pkg::REG_WET_LEVEL:   wet_q  <= cfg_data_i;
        scar_pkg::REG_PREDELAY_MS: ms_q   <= cfg_data_i[scar_pkg::MS_W-1:0];
        scar_pkg::REG_ENABLED:     en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign k_cb    = {cmd_i.ch, cmd_i.idx};
  assign k_ap    = {cmd_i.ch, cmd_i.idx[0]};
  assign cb_rd   = cmd_i.ch ? cb_r_rd_q : cb_l_rd_q;
  assign ap_rd   = cmd_i.ch ? ap_r_rd_q : ap_l_rd_q;
  assign x_wet   = cmd_i.ch ? wet_r_q : wet_l_q;
  assign dry_sel = cmd_i.ch ? dry_r_q : dry_l_q;

  // predelay length and positions
  assign pd_div_p  = 49'(pd_prod_q) * 49'(scar_pkg::RECIP_M);
  assign pd_quo    = pd_div_p[scar_pkg::RECIP_SH +: QW];
  assign plen_calc = (pd_quo == '0) ? PL_W'(1) :
                     (pd_quo > QW'(MaxPredelay)) ? PL_W'(MaxPredelay) : PL_W'(pd_quo);
  assign pd_cur    = (PL_W'(pd_pos_q) < plen_q) ? pd_pos_q : '0;
  assign pd_inc    = PL_W'(pd_cur) + PL_W'(1);
  assign pd_nxt    = (pd_inc >= plen_q) ? '0 : PD_AW'(pd_inc);

  // comb length and positions
  assign cb_len_p   = 22'(scar_pkg::comb_base(cmd_i.ch, cmd_i.idx)) * 22'(room_c);
  assign cb_len_raw = 13'(cb_len_p >> 10);
  assign clen_calc  = (cb_len_raw == '0) ? CL_W'(1) :
                      (cb_len_raw > 13'(CombDepth)) ? CL_W'(CombDepth) : CL_W'(cb_len_raw);
  assign cb_cur     = (CL_W'(cb_pos_q[k_cb]) < clen_q) ? cb_pos_q[k_cb] : '0;
  assign cb_inc     = CL_W'(cpos_q) + CL_W'(1);
  assign cb_nxt     = (cb_inc >= clen_q) ? '0 : CP_W'(cb_inc);
  assign cb_off     = CB_AW'(CombDepth) * CB_AW'(cmd_i.idx);

  // allpass positions
  assign ap_len  = cmd_i.idx[0] ? scar_pkg::AP_LEN1 : scar_pkg::AP_LEN0;
  assign ap_base = cmd_i.idx[0] ? scar_pkg::AP_OFF1 : '0;
  assign ap_cur  = (ap_pos_q[k_ap] < ap_len) ? ap_pos_q[k_ap] : '0;
  assign ap_inc  = ap_cur_q + APW'(1);
  assign ap_nxt  = (ap_inc >= ap_len) ? '0 : ap_inc;
  assign bo_half = (VW'(ap_rd) + VW'(1)) >>> 1;

  // shared MAC
  assign mul_p   = mul_a * mul_b;
  assign acc_rnd = (acc_q + AW'(512)) >>> 10;
  assign acc_sat = scar_pkg::sat(acc_rnd);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = 1'b0;
    mul_clr = 1'b0;
    case (cmd_i.op)
      scar_pkg::OP_CB_LP1: begin
        mul_a = VW'(cb_rd); mul_b = $signed({1'b0, one_m_d});
        mul_en = 1'b1; mul_clr = 1'b1;
      end
      scar_pkg::OP_CB_LP2: begin
        mul_a = VW'(lp_q[k_cb]); mul_b = $signed({1'b0, damp_c});
        mul_en = 1'b1;
      end
      scar_pkg::OP_CB_FB: begin
        mul_a = VW'(fs_q); mul_b = $signed(BW'(fb));
        mul_en = 1'b1; mul_clr = 1'b1;
      end
      scar_pkg::OP_MIX1: begin
        mul_a = VW'(dry_sel); mul_b = $signed({1'b0, one_m_w});
        mul_en = 1'b1; mul_clr = 1'b1;
      end
      scar_pkg::OP_MIX2: begin
        mul_a = v_q; mul_b = $signed(BW'(wg_q));
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    dry_l_d     = dry_l_q;
    dry_r_d     = dry_r_q;
    res_l_d     = res_l_q;
    res_r_d     = res_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_valid_d = out_valid_q && out_stall_i;
    wet_l_d     = wet_l_q;
    wet_r_d     = wet_r_q;
    pd_prod_d   = pd_prod_q;
    plen_d      = plen_q;
    pd_pos_d    = pd_pos_q;
    pd_rd_d     = pd_rd_q;
    clen_d      = clen_q;
    cpos_d      = cpos_q;
    cb_pos_d    = cb_pos_q;
    lp_d        = lp_q;
    ap_pos_d    = ap_pos_q;
    ap_cur_d    = ap_cur_q;
    sum_d       = sum_q;
    v_d         = v_q;
    fs_d        = fs_q;
    wg_d        = wg_q;
    acc_d       = mul_en ? ((mul_clr ? '0 : acc_q) + AW'(mul_p)) : acc_q;

    pd_addr = pd_cur;
    pd_we   = 1'b0;
    pd_re   = 1'b0;
    pd_wd_l = dry_l_q;
    pd_wd_r = dry_r_q;
    cb_addr = cb_off + CB_AW'(cpos_q);
    cb_we_l = 1'b0;
    cb_we_r = 1'b0;
    cb_re   = 1'b0;
    cb_wd   = scar_pkg::sat(AW'(x_wet) + acc_rnd);
    ap_addr = ap_base + ap_cur_q;
    ap_we_l = 1'b0;
    ap_we_r = 1'b0;
    ap_re   = 1'b0;
    ap_wd   = scar_pkg::sat(AW'(v_q) + AW'(bo_half));

    case (cmd_i.op)
      scar_pkg::OP_CLEAR: begin
        clr_cnt_d = clr_cnt_q + CLR_W'(1);
        pd_addr   = clr_cnt_q[PD_AW-1:0];
        pd_we     = clr_cnt_q < CLR_W'(MaxPredelay);
        pd_wd_l   = '0;
        pd_wd_r   = '0;
        cb_addr   = clr_cnt_q[CB_AW-1:0];
        cb_we_l   = clr_cnt_q < CLR_W'(CB_N);
        cb_we_r   = cb_we_l;
        cb_wd     = '0;
        ap_addr   = clr_cnt_q[APW-1:0];
        ap_we_l   = clr_cnt_q < CLR_W'(AP_N);
        ap_we_r   = ap_we_l;
        ap_wd     = '0;
      end
      scar_pkg::OP_LOAD: begin
        dry_l_d = left_in_i;
        dry_r_d = right_in_i;
        res_l_d = left_in_i;
        res_r_d = right_in_i;
      end
      scar_pkg::OP_PD_MUL: begin
        pd_prod_d = PW'(ms_q * SampleRate);
        wg_d      = wg_calc;
      end
      scar_pkg::OP_PD_DIV: plen_d = plen_calc;
      scar_pkg::OP_PD_WR: begin
        pd_we   = 1'b1;
        pd_rd_d = pd_nxt;
      end
      scar_pkg::OP_PD_RD: begin
        pd_addr  = pd_rd_q;
        pd_re    = 1'b1;
        pd_pos_d = pd_rd_q;
      end
      scar_pkg::OP_PD_TAKE: begin
        wet_l_d = pd_l_rd_q;
        wet_r_d = pd_r_rd_q;
      end
      scar_pkg::OP_CB_LEN: clen_d = clen_calc;
      scar_pkg::OP_CB_RD: begin
        cpos_d  = cb_cur;
        cb_addr = cb_off + CB_AW'(cb_cur);
        cb_re   = 1'b1;
      end
      scar_pkg::OP_CB_LP1: sum_d = ((cmd_i.idx == 2'd0) ? '0 : sum_q) + VW'(cb_rd);
      scar_pkg::OP_CB_FS: begin
        fs_d       = acc_sat;
        lp_d[k_cb] = acc_sat;
      end
      scar_pkg::OP_CB_WR: begin
        cb_we_l        = !cmd_i.ch;
        cb_we_r        = cmd_i.ch;
        cb_pos_d[k_cb] = cb_nxt;
      end
      scar_pkg::OP_AP_RD: begin
        ap_cur_d = ap_cur;
        ap_addr  = ap_base + ap_cur;
        ap_re    = 1'b1;
        if (!cmd_i.idx[0]) v_d = sum_q;
      end
      scar_pkg::OP_AP_WR: begin
        ap_we_l        = !cmd_i.ch;
        ap_we_r        = cmd_i.ch;
        ap_pos_d[k_ap] = ap_nxt;
        v_d            = VW'(ap_rd) - v_q;
      end
      scar_pkg::OP_MIX3: begin
        if (cmd_i.ch) res_r_d = acc_sat;
        else          res_l_d = acc_sat;
      end
      scar_pkg::OP_EMIT: begin
        out_l_d     = res_l_q;
        out_r_d     = res_r_q;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase

    if (rewind) begin
      pd_pos_d = '0;
      for (int i = 0; i < 8; i++) cb_pos_d[i] = '0;
      for (int i = 0; i < 4; i++) ap_pos_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pd_we) begin
      pd_l_mem[pd_addr] <= pd_wd_l;
      pd_r_mem[pd_addr] <= pd_wd_r;
    end
    if (pd_re) begin
      pd_l_rd_q <= pd_l_mem[pd_addr];
      pd_r_rd_q <= pd_r_mem[pd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cb_we_l) cb_l_mem[cb_addr] <= cb_wd;
    if (cb_we_r) cb_r_mem[cb_addr] <= cb_wd;
    if (cb_re) begin
      cb_l_rd_q <= cb_l_mem[cb_addr];
      cb_r_rd_q <= cb_r_mem[cb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ap_we_l) ap_l_mem[ap_addr] <= ap_wd;
    if (ap_we_r) ap_r_mem[ap_addr] <= ap_wd;
    if (ap_re) begin
      ap_l_rd_q <= ap_l_mem[ap_addr];
      ap_r_rd_q <= ap_r_mem[ap_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pd_pos_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        cb_pos_q[i] <= '0;
        lp_q[i]     <= '0;
      end
      for (int i = 0; i < 4; i++) ap_pos_q[i] <= '0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      pd_pos_q    <= pd_pos_d;
      cb_pos_q    <= cb_pos_d;
      lp_q        <= lp_d;
      ap_pos_q    <= ap_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dry_l_q   <= dry_l_d;
    dry_r_q   <= dry_r_d;
    res_l_q   <= res_l_d;
    res_r_q   <= res_r_d;
    out_l_q   <= out_l_d;
    out_r_q   <= out_r_d;
    wet_l_q   <= wet_l_d;
    wet_r_q   <= wet_r_d;
    pd_prod_q <= pd_prod_d;
    plen_q    <= plen_d;
    pd_rd_q   <= pd_rd_d;
    clen_q    <= clen_d;
    cpos_q    <= cpos_d;
    ap_cur_q  <= ap_cur_d;
    sum_q     <= sum_d;
    v_q       <= v_d;
    fs_q      <= fs_d;
    wg_q      <= wg_d;
    acc_q     <= acc_d;
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;
  assign sts_o       = '{enabled:  en_q,
                         clr_last: clr_cnt_q == CLR_W'(CLR_N - 1),
                         out_busy: out_valid_q && out_stall_i};

endmodule

// ----- src/stereo_comb_allpass_reverb.sv -----
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb: stereo predelay/comb/allpass reverb
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Input beats carry one stereo frame (left_in_i, right_in_i) on a valid/stall
// channel; output beats carry the mixed frame on a second valid/stall channel.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only
// while idle (not enforced by the block); room size, damping or predelay writes
// rewind all delay positions. Each frame is worked through one shared
// multiply-accumulate and single-port delay memories; when disabled the frame
// passes straight through. One frame is in flight at a time, so the next input
// beat is taken only after the last frame has gone to the output register.
// The finished frame sits in an output register; a new input beat is taken
// while it waits, and the next result is held back until it has gone.
// After reset a clearing pass zeroes the delay memories, one word per cycle,
// over max(MaxPredelay, 4*CombDepth, 1024) addresses (8192 by default) with
// in_stall_o high; configuration writes are accepted during it.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb #(
  parameter int unsigned SampleRate  = scar_pkg::SAMPLE_RATE,
  parameter int unsigned MaxPredelay = scar_pkg::MAX_PREDELAY,
  parameter int unsigned CombDepth   = scar_pkg::COMB_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scar_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [scar_pkg::COEF_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [scar_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [scar_pkg::SAMPLE_W-1:0] right_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [scar_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [scar_pkg::SAMPLE_W-1:0] right_out_o
);

  scar_pkg::dp_cmd_t cmd;
  scar_pkg::dp_sts_t sts;

  scar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scar_dp #(
    .SampleRate  (SampleRate),
    .MaxPredelay (MaxPredelay),
    .CombDepth   (CombDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- src/scar_chk.sv -----
// ----------------------------------------------------------------------------
// scar_chk: port-level checks for the stereo reverb
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
module scar_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [scar_pkg::SAMPLE_W-1:0] left_out_o,
  input logic signed [scar_pkg::SAMPLE_W-1:0] right_out_o
);

  // reset holds off both channels
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> in_stall_o && !out_valid_o)
    else $error("reset: channels not quiet");

  // one frame in flight: input closes right after a beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open after accepted beat");

  // a new result only appears after work on a frame
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a frame in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled output beat changed");

endmodule

bind stereo_comb_allpass_reverb scar_chk u_scar_chk (.*);
